// ----- hw/rtl/scnf_pkg.sv -----
package scnf_pkg;

    localparam int BASE_LEN     = 8;
    localparam int EXT_LEN      = 3;
    localparam int MAX_NAME_LEN = 11;
    localparam int ENTRY_LEN    = BASE_LEN + EXT_LEN;

    // Counter widths: the length and dot-tail counts saturate one past their limits, the fill counts at them.
    localparam int IDX_W = $clog2(ENTRY_LEN);
    localparam int CC_W  = $clog2(MAX_NAME_LEN + 2);
    localparam int BC_W  = $clog2(BASE_LEN + 1);
    localparam int EF_W  = $clog2(EXT_LEN + 1);
    localparam int AD_W  = $clog2(EXT_LEN + 2);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_E5_ALIAS = 8'h05;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_MORE   = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef struct packed {
        logic [ENTRY_LEN-1:0][7:0] bytes;
        logic                      ok;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] raise_case(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_OFFSET : c;
    endfunction

endpackage

// ----- hw/rtl/scnf_front.sv -----
module scnf_front import scnf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output logic       o_ready,
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [7:0]      r_buf [ENTRY_LEN];
    logic [7:0]      n_buf [ENTRY_LEN];
    logic [CC_W-1:0] r_cc, n_cc;
    logic [BC_W-1:0] r_bc, n_bc;
    logic [EF_W-1:0] r_ef, n_ef;
    logic [AD_W-1:0] r_ad, n_ad;
    logic            r_dot, n_dot;
    logic            r_valid, n_valid;

    logic             w_first;
    logic             w_ext_store;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_idx;
    logic             w_ok;
    logic             w_accept;

    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && i_last;

    always_comb begin
        w_first     = (r_cc == '0);
        n_cc        = r_cc;
        n_bc        = r_bc;
        n_ef        = r_ef;
        n_ad        = r_ad;
        n_dot       = r_dot;
        n_valid     = r_valid;
        w_ext_store = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_idx    = '0;

        if (r_cc <= CC_W'(MAX_NAME_LEN)) begin
            n_cc = r_cc + CC_W'(1);
        end
        if (n_cc > CC_W'(MAX_NAME_LEN)) begin
            n_valid = 1'b0;
        end
        // A leading 0x05 stands for 0xE5 and is the one control code allowed.
        if (i_char < CH_SPACE && !(w_first && i_char == CH_E5_ALIAS)) begin
            n_valid = 1'b0;
        end
        if (i_char inside {CH_QUOTE, CH_STAR, CH_PLUS, CH_COMMA, CH_SLASH, CH_COLON,
                           CH_SEMI, CH_LESS, CH_EQUAL, CH_MORE, CH_QUEST, CH_LBRACK,
                           CH_BSLASH, CH_RBRACK}) begin
            n_valid = 1'b0;
        end
        if (w_first && i_char == CH_DOT) begin
            n_valid = 1'b0;
        end

        // Only the first dot splits base from extension; later dots are stored.
        if (i_char == CH_DOT) begin
            w_ext_store = r_dot;
            n_dot       = 1'b1;
            n_ad        = '0;
        end else if (!r_dot) begin
            if (r_bc < BC_W'(BASE_LEN)) begin
                w_wr_en  = 1'b1;
                w_wr_idx = IDX_W'(r_bc);
                n_bc     = r_bc + BC_W'(1);
            end else begin
                n_valid = 1'b0;
            end
        end else begin
            w_ext_store = 1'b1;
            if (r_ad <= AD_W'(EXT_LEN)) begin
                n_ad = r_ad + AD_W'(1);
            end
        end

        if (w_ext_store) begin
            if (r_ef < EF_W'(EXT_LEN)) begin
                w_wr_en  = 1'b1;
                w_wr_idx = IDX_W'(BASE_LEN) + IDX_W'(r_ef);
                n_ef     = r_ef + EF_W'(1);
            end else begin
                n_valid = 1'b0;
            end
        end

        for (int k = 0; k < ENTRY_LEN; k++) begin
            n_buf[k] = (w_wr_en && w_wr_idx == IDX_W'(k)) ? raise_case(i_char) : r_buf[k];
        end

        w_ok = n_valid && !(n_dot && n_ad > AD_W'(EXT_LEN));

        for (int k = 0; k < ENTRY_LEN; k++) begin
            o_entry.bytes[k] = n_buf[k];
        end
        o_entry.ok = w_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            for (int k = 0; k < ENTRY_LEN; k++) begin
                r_buf[k] <= CH_SPACE;
            end
            r_cc    <= '0;
            r_bc    <= '0;
            r_ef    <= '0;
            r_ad    <= '0;
            r_dot   <= 1'b0;
            r_valid <= 1'b1;
        end else if (w_accept) begin
            r_buf   <= n_buf;
            r_cc    <= n_cc;
            r_bc    <= n_bc;
            r_ef    <= n_ef;
            r_ad    <= n_ad;
            r_dot   <= n_dot;
            r_valid <= n_valid;
        end
    end

endmodule

// ----- hw/rtl/scnf_queue.sv -----
module scnf_queue import scnf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_entry            i_entry,
    input  logic              i_pop,
    output t_entry            o_head,
    output t_q_stat           o_stat,
    output logic [QCNT_W-1:0] o_count
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic                w_push;
    logic                w_pop;

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rp];
    assign o_count      = r_cnt;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/scnf_back.sv -----
module scnf_back import scnf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_entry     i_head,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_ok,
    output logic       o_last,
    input  logic       i_ready
);

    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_ok;
    logic             r_last;
    logic [IDX_W-1:0] r_idx;

    logic w_load;
    logic w_take;
    logic w_end;

    // The output register refills whenever it is empty or its beat is taken.
    assign w_load = !r_valid || i_ready;
    assign w_take = w_load && !i_q_stat.empty;
    assign w_end  = (r_idx == IDX_W'(ENTRY_LEN - 1));
    assign o_pop  = w_take && w_end;

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_ok    = r_ok;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= !i_q_stat.empty;
            if (w_take) begin
                r_idx <= w_end ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_head.bytes[r_idx];
            r_ok   <= i_head.ok;
            r_last <= w_end;
        end
    end

endmodule

// ----- hw/rtl/short_name_check_and_format_core.sv -----
// The first of the 11 entry bytes passes the queue and then the output register.
// Throughput: one character per cycle in; one entry byte per cycle out while the receiver
// is ready, 11 beats per name. A two-name queue parts the sides; input stalls only while two
// finished names wait. Reset (i_rst_n low at a clock edge) empties the queue and output
// register and restores the name buffer to spaces with all counts cleared.
module short_name_check_and_format_core import scnf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] entry_byte
    output logic       o_m_axis_tuser,   // [0] name_ok
    output logic       o_m_axis_tlast
);

    t_entry              w_push_entry;
    t_entry              w_head;
    t_q_stat             w_q_stat;
    logic                w_push;
    logic                w_pop;
    logic [QCNT_W-1:0]   w_q_count;

    scnf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_char   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_ready  (o_s_axis_tready),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    scnf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat),
        .o_count (w_q_count)
    );

    scnf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .o_byte   (o_m_axis_tdata),
        .o_ok     (o_m_axis_tuser),
        .o_last   (o_m_axis_tlast),
        .i_ready  (i_m_axis_tready)
    );

`ifndef SYNTH
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_count <= QCNT_W'(QDEPTH))
        else $error("queue count past its depth");

    a_name_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> (w_q_count != '0))
        else $error("finished name missing from queue");

    a_name_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast)
        |=> (o_m_axis_tvalid && o_m_axis_tuser == $past(o_m_axis_tuser)))
        else $error("entry bytes of one name broken up or flag changed");
`endif

endmodule

// ----- verif/short_name_check_and_format_core_test.sv -----
`timescale 1ns / 1ps

module short_name_check_and_format_core_test;
    import scnf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 4;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [7:0] ch;
        logic       ok;
        logic       fin;
    } t_entry_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data;
    logic       s_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_data;
    logic       m_user;
    logic       m_last;

    short_name_check_and_format_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] char_in
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [7:0] entry_byte
        .o_m_axis_tuser  (m_user),   // [0] name_ok
        .o_m_axis_tlast  (m_last)
    );

    // Shadow of the name being assembled.
    logic [7:0]  name_buf [ENTRY_LEN];
    int          len_cnt;
    int          base_cnt;
    int          ext_cnt;
    int          tail_cnt;
    bit          has_dot;
    bit          good;

    t_entry_beat entry_q [$];

    int  err_cnt       = 0;
    int  chars_sent    = 0;
    int  names_seen    = 0;
    int  names_valid   = 0;
    int  idle_cycles   = 0;
    int  rx_stall_left = 0;
    bit  steady        = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= "a" && c <= "z") begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    function automatic bit is_forbidden(input logic [7:0] c);
        case (c)
            CH_QUOTE, CH_STAR, CH_PLUS, CH_COMMA, CH_SLASH, CH_COLON, CH_SEMI,
            CH_LESS, CH_EQUAL, CH_MORE, CH_QUEST, CH_LBRACK, CH_BSLASH,
            CH_RBRACK: begin
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic clear_name();
        for (int k = 0; k < ENTRY_LEN; k++) begin
            name_buf[k] = CH_SPACE;
        end
        len_cnt  = 0;
        base_cnt = 0;
        ext_cnt  = 0;
        tail_cnt = 0;
        has_dot  = 1'b0;
        good     = 1'b1;
    endtask

    task automatic put_ext(input logic [7:0] c);
        if (ext_cnt < EXT_LEN) begin
            name_buf[BASE_LEN + ext_cnt] = upcase(c);
            ext_cnt++;
        end else begin
            good = 1'b0;
        end
    endtask

    // Folds one accepted character into the shadow name; the final one
    // queues the eleven entry beats that the block has to produce.
    task automatic absorb_char(input logic [7:0] c, input logic last);
        bit          first;
        bit          ok;
        t_entry_beat beat;
        first = (len_cnt == 0);
        if (len_cnt <= MAX_NAME_LEN) begin
            len_cnt++;
        end
        if (len_cnt > MAX_NAME_LEN) begin
            good = 1'b0;
        end
        if (c < CH_SPACE && !(first && c == CH_E5_ALIAS)) begin
            good = 1'b0;
        end
        if (is_forbidden(c)) begin
            good = 1'b0;
        end
        if (first && c == CH_DOT) begin
            good = 1'b0;
        end
        if (c == CH_DOT) begin
            // Dots after the first one land in the extension.
            if (has_dot) begin
                put_ext(c);
            end
            has_dot  = 1'b1;
            tail_cnt = 0;
        end else if (!has_dot) begin
            if (base_cnt < BASE_LEN) begin
                name_buf[base_cnt] = upcase(c);
                base_cnt++;
            end else begin
                good = 1'b0;
            end
        end else begin
            put_ext(c);
            if (tail_cnt <= EXT_LEN) begin
                tail_cnt++;
            end
        end
        if (last) begin
            ok = good && !(has_dot && tail_cnt > EXT_LEN);
            for (int k = 0; k < ENTRY_LEN; k++) begin
                beat.ch  = name_buf[k];
                beat.ok  = ok;
                beat.fin = (k == ENTRY_LEN - 1);
                entry_q.insert(entry_q.size(), beat);
            end
            clear_name();
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 8) begin
            gap = 1;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        s_last  <= last;
        @(posedge i_clk);
        while (!s_ready) begin
            @(posedge i_clk);
        end
        absorb_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], i == txt.len() - 1);
        end
    endtask

    function automatic logic [7:0] pick_legal();
        case ($urandom_range(0, 5))
            0, 1: begin
                return 8'($urandom_range("a", "z"));
            end
            2: begin
                return 8'($urandom_range("A", "Z"));
            end
            3: begin
                return 8'($urandom_range("0", "9"));
            end
            4: begin
                return 8'($urandom_range(8'h80, 8'hFF));
            end
            default: begin
                return ($urandom_range(0, 1) != 0) ? "_" : "~";
            end
        endcase
    endfunction

    // Well-formed names get deep into the base and extension paths; the
    // rest mixes in raw bytes, stray dots and overlong lengths.
    task automatic send_random_name(input bit well_formed);
        logic [7:0] chars [0:15];
        int         len;
        int         n_ext;
        if (well_formed) begin
            len = $urandom_range(1, BASE_LEN);
            for (int i = 0; i < len; i++) begin
                chars[i] = pick_legal();
            end
            if ($urandom_range(0, 99) < 70) begin
                n_ext      = $urandom_range(0, EXT_LEN);
                chars[len] = CH_DOT;
                len++;
                for (int i = 0; i < n_ext; i++) begin
                    chars[len] = pick_legal();
                    len++;
                end
            end
        end else begin
            len = $urandom_range(1, 14);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: chars[i] = 8'($urandom_range(0, 255));
                    4, 5:       chars[i] = CH_DOT;
                    default:    chars[i] = pick_legal();
                endcase
            end
        end
        for (int i = 0; i < len; i++) begin
            send_char(chars[i], i == len - 1);
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (entry_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_names();
        send_char(8'h00, 1'b1);                      // control byte alone
        send_char(8'hFF, 1'b1);                      // high byte kept as is
        send_char(CH_E5_ALIAS, 1'b0);
        send_char("z", 1'b1);
        send_char(CH_DOT, 1'b0);                     // leading dot
        send_char(CH_STAR, 1'b1);
        send_text("ab.");                            // empty extension
        send_text("q.b.cd");                         // extension overflow
        send_text("abcdefghijk");                    // base overflow
        release_input();
        wait_drained();
    endtask

    task automatic test_random_names(input int n_chars);
        int stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            send_random_name($urandom_range(0, 99) < 75);
        end
        release_input();
        wait_drained();
    endtask

    task automatic test_back_to_back(input int n_chars);
        int stop_at;
        stop_at = chars_sent + n_chars;
        steady  = 1'b1;
        while (chars_sent < stop_at) begin
            send_random_name($urandom_range(0, 99) < 85);
        end
        steady = 1'b0;
        release_input();
        wait_drained();
    endtask

    // The receiver stops for a long stretch while names keep coming, so the
    // two-name queue fills and the input side has to stall.
    task automatic test_output_hold_off();
        rx_stall_left = HOLD_CYCLES;
        for (int i = 0; i < 10; i++) begin
            send_random_name(1'b1);
        end
        release_input();
        wait_drained();
    endtask

    always begin
        @(negedge i_clk);
        if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge i_clk) begin
        t_entry_beat want;
        if (i_rst_n && m_valid && m_ready) begin
            if (entry_q.size() == 0) begin
                $error("unexpected entry beat: byte %h ok %b last %b",
                       m_data, m_user, m_last);
                err_cnt++;
            end else begin
                want = entry_q.pop_front();
                if (m_data !== want.ch) begin
                    $error("entry_byte: expected %h, got %h", want.ch, m_data);
                    err_cnt++;
                end
                if (m_user !== want.ok) begin
                    $error("name_ok: expected %b, got %b", want.ok, m_user);
                    err_cnt++;
                end
                if (m_last !== want.fin) begin
                    $error("final_byte: expected %b, got %b", want.fin, m_last);
                    err_cnt++;
                end
                if (want.fin) begin
                    names_seen++;
                    if (want.ok) begin
                        names_valid++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("short_name_check_and_format_core_test: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = 8'h00;
        s_last  = 1'b0;
        m_ready = 1'b0;
        clear_name();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_names();
        test_random_names(330);
        test_back_to_back(60);
        test_output_hold_off();

        $display("%0d characters sent, %0d names checked, %0d of them valid",
                 chars_sent, names_seen, names_valid);
        $display("covered: special bytes, overflows, dotted extensions, steady flow, full queue");
        if (err_cnt == 0) begin
            $display("short_name_check_and_format_core_test: done, clean");
        end else begin
            $display("short_name_check_and_format_core_test: done, errors");
        end
        $finish;
    end

endmodule
